// ===== hdl/u2h_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 to UTF-16BE hex transcoder.
// Used by the decoder, the code point queue and the hex emitter.
package u2h_pkg;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   // Lead byte thresholds
   localparam logic [7:0] TwoByteLead   = 8'h80;
   localparam logic [7:0] ThreeByteLead = 8'hE0;
   localparam logic [7:0] FourByteLead  = 8'hF0;

   localparam logic [20:0] BmpLimit = 21'h00FFFF;
   localparam logic [20:0] SuppBase = 21'h010000;
   localparam logic [15:0] HighSurr = 16'hD800;
   localparam logic [15:0] LowSurr  = 16'hDC00;

   // Digit counts, zero based: last digit of a single unit and of a pair
   localparam logic [2:0] LastDigitUnit = 3'd3;
   localparam logic [2:0] LastDigitPair = 3'd7;

   typedef struct packed {
      logic [20:0] code_point;
      logic        end_of_text;
   } cp_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
      logic [6:0] code;
      if (nib < 4'd10) begin
         code = 7'h30 + {3'b000, nib};
      end else begin
         code = 7'h37 + {3'b000, nib};
      end
      return code;
   endfunction

endpackage

// ===== hdl/u2h_front.sv =====
// Byte decoder: accepts UTF-8 bytes, assembles code points, hands finished ones on.
// Depends on u2h_pkg.
module u2h_front import u2h_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] byte_value
   input  logic         req_tlast,   // end_of_text
   input  logic         queue_full,
   output logic         push,
   output cp_entry_type push_entry
);

   logic [20:0] acc_ff, acc_in;
   logic [1:0]  rem_ff, rem_in;
   logic [20:0] acc_next;
   logic [1:0]  rem_next;
   logic        accept;
   logic        done;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (rem_ff == 2'd0) begin
         if (req_tdata < TwoByteLead) begin
            acc_next = {13'd0, req_tdata};
            rem_next = 2'd0;
         end else if (req_tdata < ThreeByteLead) begin
            acc_next = {16'd0, req_tdata[4:0]};
            rem_next = 2'd1;
         end else if (req_tdata < FourByteLead) begin
            acc_next = {17'd0, req_tdata[3:0]};
            rem_next = 2'd2;
         end else begin
            acc_next = {18'd0, req_tdata[2:0]};
            rem_next = 2'd3;
         end
      end else begin
         // continuation bytes are taken unchecked
         acc_next = {acc_ff[14:0], req_tdata[5:0]};
         rem_next = rem_ff - 2'd1;
      end
   end

   // a short text ends the sequence early and flushes what is there
   assign done = (rem_next == 2'd0) || req_tlast;
   assign push = accept && done;
   assign push_entry.code_point  = acc_next;
   assign push_entry.end_of_text = req_tlast;

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      if (accept) begin
         if (done) begin
            acc_in = '0;
            rem_in = 2'd0;
         end else begin
            acc_in = acc_next;
            rem_in = rem_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= 2'd0;
      end else begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== hdl/u2h_fifo.sv =====
// Short queue of finished code points between the decoder and the emitter.
// Depends on u2h_pkg.
module u2h_fifo import u2h_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cp_entry_type     push_entry,
   input  logic             pop,
   output cp_entry_type     head,
   output queue_status_type status
);

   cp_entry_type       mem_ff [QueueDepth];
   logic [QueueAw:0]   wptr_ff, wptr_in;
   logic [QueueAw:0]   rptr_ff, rptr_in;

   assign status.empty = (wptr_ff == rptr_ff);
   assign status.full  = (wptr_ff[QueueAw] != rptr_ff[QueueAw]) &&
                         (wptr_ff[QueueAw-1:0] == rptr_ff[QueueAw-1:0]);
   assign head = mem_ff[rptr_ff[QueueAw-1:0]];

   assign wptr_in = (push && !status.full) ? wptr_ff + {{QueueAw{1'b0}}, 1'b1} : wptr_ff;
   assign rptr_in = (pop && !status.empty) ? rptr_ff + {{QueueAw{1'b0}}, 1'b1} : rptr_ff;

   always_ff @(posedge clock) begin
      if (push && !status.full) begin
         mem_ff[wptr_ff[QueueAw-1:0]] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

endmodule

// ===== hdl/u2h_back.sv =====
// Hex emitter: splits each code point into UTF-16 units and sends one hex digit a word.
// Depends on u2h_pkg.
module u2h_back import u2h_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cp_entry_type     head,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [6:0] hex_char, [7] zero
   output logic             rsp_tuser,   // last_of_code_point
   output logic             rsp_tlast    // last_of_text
);

   logic        busy_ff, busy_in;
   logic [31:0] units_ff, units_in;
   logic        long_ff, long_in;
   logic        end_ff, end_in;
   logic [2:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [6:0]  out_char_ff, out_char_in;
   logic        out_lcp_ff, out_lcp_in;
   logic        out_lot_ff, out_lot_in;

   logic        step;
   logic        last_digit;
   logic        load;
   logic        head_long;
   logic [20:0] head_off;
   logic [15:0] hi_unit;
   logic [15:0] lo_unit;

   assign step       = busy_ff && (!out_valid_ff || rsp_tready);
   assign last_digit = (idx_ff == (long_ff ? LastDigitPair : LastDigitUnit));
   assign load       = !status.empty && (!busy_ff || (step && last_digit));
   assign pop        = load;

   assign head_long = (head.code_point > BmpLimit);
   assign head_off  = head.code_point - SuppBase;
   assign hi_unit   = HighSurr + {5'd0, head_off[20:10]};
   assign lo_unit   = LowSurr + {6'd0, head_off[9:0]};

   always_comb begin
      busy_in  = busy_ff;
      units_in = units_ff;
      long_in  = long_ff;
      end_in   = end_ff;
      idx_in   = idx_ff;
      if (step) begin
         units_in = {units_ff[27:0], 4'h0};
         idx_in   = idx_ff + 3'd1;
         if (last_digit) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         long_in  = head_long;
         end_in   = head.end_of_text;
         idx_in   = 3'd0;
         // single units sit in the top half so digits always leave from the top
         units_in = head_long ? {hi_unit, lo_unit} : {head.code_point[15:0], 16'h0000};
      end
   end

   always_comb begin
      out_char_in  = out_char_ff;
      out_lcp_in   = out_lcp_ff;
      out_lot_in   = out_lot_ff;
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_char_in  = hex_ascii(units_ff[31:28]);
         out_lcp_in   = last_digit;
         out_lot_in   = last_digit && end_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      units_ff    <= units_in;
      long_ff     <= long_in;
      end_ff      <= end_in;
      out_char_ff <= out_char_in;
      out_lcp_ff  <= out_lcp_in;
      out_lot_ff  <= out_lot_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tuser  = out_lcp_ff;
   assign rsp_tlast  = out_lot_ff;

endmodule

// ===== hdl/utf8_to_utf16be_hex.sv =====
// Top level of the UTF-8 to UTF-16BE hex transcoder.
// Instantiates u2h_front, u2h_fifo and u2h_back; depends on u2h_pkg.
//
// Takes UTF-8 text one byte a word (tlast marks the final byte) and returns,
// for each code point, its UTF-16BE code units as uppercase ASCII hex digits,
// one digit a word: four for a code point up to FFFF, eight (high then low
// surrogate) above it. tuser flags the final digit of a code point and tlast
// the final digit of the text. Nothing is validated; a text cut short
// mid-sequence flushes the partial value as it stands. The decoder takes a
// byte every cycle while its four-entry code point queue has room; the hex
// emitter sends one digit per cycle while the output is ready, so each code
// point yields four or eight digits and plain ASCII gives four digits per byte.
module utf8_to_utf16be_hex import u2h_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] hex_char, [7] zero
   output logic       rsp_tuser,   // last_of_code_point
   output logic       rsp_tlast    // last_of_text
);

   logic             push;
   cp_entry_type     push_entry;
   logic             pop;
   cp_entry_type     head;
   queue_status_type q_status;

   u2h_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (q_status.full),
      .push       (push),
      .push_entry (push_entry)
   );

   u2h_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   u2h_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_lot_ends_cp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("end of text not on a code point boundary");

   a_hex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
                     (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h46))
      else $error("output word is not an uppercase hex digit");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("code point queue both full and empty");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("emitter popped an empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("decoder pushed into a full queue");

endmodule
